FILE: rtl/ihm_pkg.sv
// ihm_pkg: widths, register codes, reset values and control types shared
// by the Ising Hamiltonian product block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ihm_pkg;

  localparam int MAX_SITES_DEF = 10;

  localparam int IDX_W      = 10;
  localparam int VAL_W      = 24;
  localparam int COEF_W     = 16;
  localparam int NSITES_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RES_W      = 48;

  // sized for up to sixteen sites
  localparam int DIAG_W  = 22;
  localparam int FLIP_W  = 29;
  localparam int MUL_A_W = 29;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [NSITES_W-1:0]      NSITES_RST = 4'd2;
  localparam logic signed [COEF_W-1:0] COUP_J_RST = 16'sd4096;
  localparam logic signed [COEF_W-1:0] FIELD_RST  = 16'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_SITES  = 2'd0,
    REG_COUPLING_J = 2'd1,
    REG_FIELD_H    = 2'd2,
    REG_FIELD_G    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_sub;
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/ihm_vec_mem.sv
// ihm_vec_mem: state vector memory, one write and one registered read port.
// Depends on ihm_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

module ihm_vec_mem
  import ihm_pkg::*;
#(
  parameter int ADDR_W = MAX_SITES_DEF
) (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [ADDR_W-1:0]        wr_addr,
  input  wire signed [VAL_W-1:0]  wr_data,
  input  wire [ADDR_W-1:0]        rd_addr,
  output logic signed [VAL_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/ihm_mac.sv
// ihm_mac: shared signed multiplier with a registered product and a 48-bit
// accumulator that loads or subtracts the product. Depends on ihm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihm_mac
  import ihm_pkg::*;
(
  input  wire                       clk,
  input  wire mac_ctrl_t            ctrl,
  input  wire signed [MUL_A_W-1:0]  op_a,
  input  wire signed [MUL_B_W-1:0]  op_b,
  output logic signed [RES_W-1:0]   acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [RES_W-1:0]  acc_r;
  logic signed [RES_W-1:0]  prod_lo;

  assign prod_lo = $signed(prod_r[RES_W-1:0]);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctrl.acc_load) begin
      acc_r <= prod_lo;
    end else if (ctrl.acc_sub) begin
      acc_r <= acc_r - prod_lo;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

FILE: rtl/ising_hamiltonian_matvec.sv
// ising_hamiltonian_matvec: top level, sequencer, config registers and
// output register. Depends on ihm_pkg, ihm_vec_mem and ihm_mac.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_ready  req_type, elem_index, elem_value
//   out_     out  out_valid/out_ready result_index, product_value
//   cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// a load beat writes the vector memory in its own cycle; ready again next cycle
// a query holds the block after its beat until its result moves out: n + 1 memory reads
// through the single read port, then two passes through the shared multiplier
// reset is synchronous and clears control and config; the vector memory is not cleared
// a finished result waits in the sequencer while the output register is full
`timescale 1ns / 1ps
`default_nettype none

module ising_hamiltonian_matvec
  import ihm_pkg::*;
#(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire                       in_req_type,
  input  wire [IDX_W-1:0]           in_elem_index,
  input  wire signed [VAL_W-1:0]    in_elem_value,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic [IDX_W-1:0]          out_result_index,
  output logic signed [RES_W-1:0]   out_product_value,
  input  wire                       cfg_we,
  input  wire [CFG_IDX_W-1:0]       cfg_index,
  input  wire [CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int ADDR_W = MAX_SITES;
  localparam int CNT_W  = $clog2(MAX_SITES + 1);
  localparam int SITE_W = $clog2(MAX_SITES);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LAST, S_MUL1, S_MUL2, S_SUB, S_OUT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]         c_r, c_nxt;
  logic signed [DIAG_W-1:0]  diag_r, diag_nxt;
  logic signed [FLIP_W-1:0]  flip_r, flip_nxt;
  logic signed [VAL_W-1:0]   vc_r, vc_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic                      rd_first_r, rd_first_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]          out_index_r, out_index_nxt;
  logic signed [RES_W-1:0]   out_value_r, out_value_nxt;

  logic [NSITES_W-1:0]       num_sites_r;
  logic signed [COEF_W-1:0]  coupling_j_r;
  logic signed [COEF_W-1:0]  field_h_r;
  logic signed [COEF_W-1:0]  field_g_r;

  logic [CNT_W-1:0]          n_use;
  logic [ADDR_W:0]           mask_full;
  logic [ADDR_W-1:0]         mask;
  logic [ADDR_W-1:0]         in_c;
  logic                      accept;
  logic [SITE_W-1:0]         site_idx;
  logic [SITE_W-1:0]         nb_idx;
  logic [ADDR_W-1:0]         flip_bit;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [VAL_W-1:0]   rd_data;
  logic                      bit_a, bit_b;
  logic signed [DIAG_W-1:0]  j_ext, h_ext, j_term, h_term;
  mac_ctrl_t                 mac_ctrl;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [RES_W-1:0]   mac_acc;

  // active site count, clamped to one..MAX_SITES
  always_comb begin
    if (num_sites_r == '0) begin
      n_use = CNT_W'(1);
    end else if (int'(num_sites_r) > MAX_SITES) begin
      n_use = CNT_W'(MAX_SITES);
    end else begin
      n_use = CNT_W'(num_sites_r);
    end
  end

  assign mask_full = ((ADDR_W + 1)'(1) << n_use) - (ADDR_W + 1)'(1);
  assign mask      = mask_full[ADDR_W-1:0];
  assign in_c      = ADDR_W'(in_elem_index) & mask;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // read 0 is the center entry, read k flips bit k-1
  assign site_idx = SITE_W'(cnt_r - CNT_W'(1));
  assign nb_idx   = (cnt_r == n_use) ? '0 : SITE_W'(cnt_r);
  assign flip_bit = ADDR_W'(1) << site_idx;
  assign rd_addr  = (cnt_r == '0) ? c_r : (c_r ^ flip_bit);
  assign bit_a    = c_r[site_idx];
  assign bit_b    = c_r[nb_idx];

  assign j_ext  = DIAG_W'(coupling_j_r);
  assign h_ext  = DIAG_W'(field_h_r);
  assign j_term = (bit_a == bit_b) ? -j_ext : j_ext;
  assign h_term = bit_a ? -h_ext : h_ext;

  ihm_vec_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept && (req_t'(in_req_type) == REQ_LOAD)),
    .wr_addr (in_c),
    .wr_data (in_elem_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ihm_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    c_nxt         = c_r;
    diag_nxt      = diag_r;
    flip_nxt      = flip_r;
    vc_nxt        = vc_r;
    rd_vld_nxt    = 1'b0;
    rd_first_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    mac_ctrl      = '0;
    mac_a         = MUL_A_W'(diag_r);
    mac_b         = vc_r;

    // memory data lands in the cycle after its address
    if (rd_vld_r) begin
      if (rd_first_r) begin
        vc_nxt = rd_data;
      end else begin
        flip_nxt = flip_r + FLIP_W'(rd_data);
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept && (req_t'(in_req_type) == REQ_QUERY)) begin
          c_nxt     = in_c;
          cnt_nxt   = '0;
          diag_nxt  = '0;
          flip_nxt  = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        rd_vld_nxt   = 1'b1;
        rd_first_nxt = (cnt_r == '0);
        if (cnt_r != '0) begin
          diag_nxt = diag_r + j_term + h_term;
        end
        if (cnt_r == n_use) begin
          state_nxt = S_LAST;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_LAST: begin
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = S_MUL2;
      end
      S_MUL2: begin
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.acc_load = 1'b1;
        mac_a             = MUL_A_W'(flip_r);
        mac_b             = MUL_B_W'(field_g_r);
        state_nxt         = S_SUB;
      end
      S_SUB: begin
        mac_ctrl.acc_sub = 1'b1;
        state_nxt        = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = IDX_W'(c_r);
          out_value_nxt = mac_acc;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_vld_r     <= 1'b0;
      rd_first_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      num_sites_r  <= NSITES_RST;
      coupling_j_r <= COUP_J_RST;
      field_h_r    <= FIELD_RST;
      field_g_r    <= FIELD_RST;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_first_r  <= rd_first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_NUM_SITES:  num_sites_r  <= cfg_wdata[NSITES_W-1:0];
          REG_COUPLING_J: coupling_j_r <= $signed(cfg_wdata[COEF_W-1:0]);
          REG_FIELD_H:    field_h_r    <= $signed(cfg_wdata[COEF_W-1:0]);
          REG_FIELD_G:    field_g_r    <= $signed(cfg_wdata[COEF_W-1:0]);
          default: begin
          end
        endcase
      end
    end
    cnt_r       <= cnt_nxt;
    c_r         <= c_nxt;
    diag_r      <= diag_nxt;
    flip_r      <= flip_nxt;
    vc_r        <= vc_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_index  = out_index_r;
  assign out_product_value = out_value_r;

endmodule

`default_nettype wire
